@@ rtl/mes_pkg.sv @@
package mes_pkg;

  typedef enum logic [1:0] {
    CMD_PART = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam int unsigned STYLE_W = 3;
  localparam int unsigned BOLD_B   = 0;
  localparam int unsigned ITALIC_B = 1;
  localparam int unsigned STRIKE_B = 2;

  // one bit per output slot, emitted lowest first
  localparam int unsigned SLOT_W = 13;
  localparam int unsigned SL_CLS0 = 0;
  localparam int unsigned SL_CLS1 = 1;
  localparam int unsigned SL_CLI  = 2;
  localparam int unsigned SL_CLB0 = 3;
  localparam int unsigned SL_CLB1 = 4;
  localparam int unsigned SL_OPB0 = 5;
  localparam int unsigned SL_OPB1 = 6;
  localparam int unsigned SL_OPI  = 7;
  localparam int unsigned SL_OPS0 = 8;
  localparam int unsigned SL_OPS1 = 9;
  localparam int unsigned SL_ESC  = 10;
  localparam int unsigned SL_DATA = 11;
  localparam int unsigned SL_ZERO = 12;

  localparam logic [SLOT_W-1:0] TILDE_SLOTS = 13'b0_0011_0000_0011;
  localparam logic [SLOT_W-1:0] STAR_SLOTS  = 13'b0_0000_1111_1100;
  localparam logic [SLOT_W-1:0] ESC_SLOTS   = 13'b0_0100_0000_0000;
  localparam logic [SLOT_W-1:0] DATA_SLOTS  = 13'b0_1000_0000_0000;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0]         command;
    logic [STYLE_W-1:0] style_bits;
    logic [7:0]         in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slots;
    logic [7:0]        data;
  } job_t;

endpackage

@@ rtl/markdown_emphasis_serializer_top.sv @@
// channel  | direction | handshake                    | payload
// input    | in        | push / full (accept: push & !full)  | in_item  (in_item_t)
// result   | out       | empty / pop (accept: pop & !empty)  | out_item (out_item_t)
//
// the back end emits the result bytes of an item in turn; an item with n results
// occupies it until all n are out (1 for a plain byte, 2 escaped, up to 6 for end)
// the front end takes one item per cycle while the job queue has room
// an accepted item goes through the job queue and the slot register into the result buffer
// synchronous active-low reset clears style, queues and the result buffer
// a held result stalls the back end only once both buffer entries are full
module markdown_emphasis_serializer_top
  import mes_pkg::*;
#(
  parameter int JOB_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic job_push, q_full, q_empty, q_pop;
  job_t job_in, job_out;

  mes_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .q_full   (q_full),
    .in_item  (in_item),
    .full     (full),
    .job_push (job_push),
    .job      (job_in)
  );

  mes_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .rd_en   (q_pop),
    .rd_job  (job_out),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  mes_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (job_out),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

@@ rtl/mes_front.sv @@
module mes_front
  import mes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     q_full,
  input  in_item_t in_item,
  output logic     full,
  output logic     job_push,
  output job_t     job
);

  logic [STYLE_W-1:0] style_r, style_nxt;
  logic [STYLE_W-1:0] cls, opn;
  logic               esc, dat, zro;
  logic               accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    cls       = '0;
    opn       = '0;
    esc       = 1'b0;
    dat       = 1'b0;
    zro       = 1'b0;
    style_nxt = style_r;
    unique case (cmd_t'(in_item.command))
      CMD_PART: begin
        cls       = style_r & ~in_item.style_bits;
        opn       = ~style_r & in_item.style_bits;
        style_nxt = in_item.style_bits;
      end
      CMD_BYTE: begin
        dat = 1'b1;
        esc = (in_item.in_byte == CH_STAR) || (in_item.in_byte == CH_UNDER) ||
              (in_item.in_byte == CH_TILDE) || (in_item.in_byte == CH_BSL);
      end
      CMD_END: begin
        cls       = style_r;
        zro       = 1'b1;
        style_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    job.slots          = '0;
    job.slots[SL_CLS0] = cls[STRIKE_B];
    job.slots[SL_CLS1] = cls[STRIKE_B];
    job.slots[SL_CLI]  = cls[ITALIC_B];
    job.slots[SL_CLB0] = cls[BOLD_B];
    job.slots[SL_CLB1] = cls[BOLD_B];
    job.slots[SL_OPB0] = opn[BOLD_B];
    job.slots[SL_OPB1] = opn[BOLD_B];
    job.slots[SL_OPI]  = opn[ITALIC_B];
    job.slots[SL_OPS0] = opn[STRIKE_B];
    job.slots[SL_OPS1] = opn[STRIKE_B];
    job.slots[SL_ESC]  = esc;
    job.slots[SL_DATA] = dat;
    job.slots[SL_ZERO] = zro;
    job.data           = in_item.in_byte;
  end

  // items that produce nothing (same style, unused command) are dropped here
  assign job_push = accept && (job.slots != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= '0;
    end else if (accept) begin
      style_r <= style_nxt;
    end
  end

endmodule

@@ rtl/mes_jobq.sv @@
module mes_jobq
  import mes_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_empty,
  output logic q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == DEPTH_C);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == LAST_P) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == LAST_P) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/mes_back.sv @@
module mes_back
  import mes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic [SLOT_W-1:0] slots_r, slots_nxt, low, rest, slots_after;
  logic [7:0]        data_r, data_nxt;
  logic              emit, load;
  out_item_t         emit_item;

  out_item_t         head_r, head_nxt, tail_r, tail_nxt;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic              do_pop;

  // lowest pending slot goes out first
  assign low  = slots_r & (~slots_r + 1'b1);
  assign rest = slots_r & ~low;
  assign emit = (slots_r != '0) && (ocnt_r != 2'd2);

  always_comb begin
    priority if ((low & TILDE_SLOTS) != '0) begin
      emit_item.out_byte = CH_TILDE;
    end else if ((low & STAR_SLOTS) != '0) begin
      emit_item.out_byte = CH_STAR;
    end else if ((low & ESC_SLOTS) != '0) begin
      emit_item.out_byte = CH_BSL;
    end else if ((low & DATA_SLOTS) != '0) begin
      emit_item.out_byte = data_r;
    end else begin
      emit_item.out_byte = CH_NUL;
    end
    emit_item.last_of_run = (rest == '0);
  end

  always_comb begin
    slots_after = emit ? rest : slots_r;
    load        = (slots_after == '0) && !q_empty;
    slots_nxt   = load ? q_job.slots : slots_after;
    data_nxt    = load ? q_job.data : data_r;
  end

  assign q_pop = load;

  // two-entry result queue
  assign empty    = (ocnt_r == 2'd0);
  assign out_item = head_r;
  assign do_pop   = pop && !empty;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    ocnt_nxt = ocnt_r;
    priority if (do_pop && emit) begin
      if (ocnt_r == 2'd1) begin
        head_nxt = emit_item;
      end else begin
        head_nxt = tail_r;
        tail_nxt = emit_item;
      end
    end else if (emit) begin
      if (ocnt_r == 2'd0) begin
        head_nxt = emit_item;
      end else begin
        tail_nxt = emit_item;
      end
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (do_pop) begin
      head_nxt = tail_r;
      ocnt_nxt = ocnt_r - 2'd1;
    end else begin
      ocnt_nxt = ocnt_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
      ocnt_r  <= '0;
    end else begin
      slots_r <= slots_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

endmodule

@@ rtl/mes_checker.sv @@
module mes_props
  import mes_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input in_item_t  in_item,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // queues come out of reset drained
  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (empty && !full))
    else $error("queues not clear after reset");

  // a waiting result request holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  // a zero byte always ends its run
  a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.out_byte == CH_NUL) |-> out_item.last_of_run)
    else $error("zero byte not last of run");

  // only tokens and the escape can precede more bytes of the same item
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.last_of_run) |->
      (out_item.out_byte == CH_TILDE || out_item.out_byte == CH_STAR ||
       out_item.out_byte == CH_BSL))
    else $error("unexpected byte inside a run");

endmodule

bind markdown_emphasis_serializer_top mes_props u_mes_props (.*);

@@ test/mes_checker.sv @@
`timescale 1ns / 1ps

module mes_checker
  import mes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item,
  output int        errors,
  output int        pending,
  output int        requests,
  output int        bytes_checked
);

  logic [STYLE_W-1:0] open_style;
  out_item_t          md_bytes_due[$];

  task automatic predict_markdown(input in_item_t req);
    logic [7:0]         run[$];
    logic [STYLE_W-1:0] next_style;
    cmd_t               cmd;
    cmd = cmd_t'(req.command);
    next_style = open_style;
    if (cmd == CMD_PART) begin
      next_style = req.style_bits;
    end else if (cmd == CMD_END) begin
      next_style = '0;
    end
    if (cmd == CMD_PART || cmd == CMD_END) begin
      // closing order: strike, italic, bold
      if (open_style[STRIKE_B] && !next_style[STRIKE_B]) begin
        run.push_back(CH_TILDE);
        run.push_back(CH_TILDE);
      end
      if (open_style[ITALIC_B] && !next_style[ITALIC_B]) begin
        run.push_back(CH_STAR);
      end
      if (open_style[BOLD_B] && !next_style[BOLD_B]) begin
        run.push_back(CH_STAR);
        run.push_back(CH_STAR);
      end
    end
    if (cmd == CMD_PART) begin
      // opening order: bold, italic, strike
      if (!open_style[BOLD_B] && next_style[BOLD_B]) begin
        run.push_back(CH_STAR);
        run.push_back(CH_STAR);
      end
      if (!open_style[ITALIC_B] && next_style[ITALIC_B]) begin
        run.push_back(CH_STAR);
      end
      if (!open_style[STRIKE_B] && next_style[STRIKE_B]) begin
        run.push_back(CH_TILDE);
        run.push_back(CH_TILDE);
      end
    end else if (cmd == CMD_END) begin
      run.push_back(CH_NUL);
    end else if (cmd == CMD_BYTE) begin
      if (req.in_byte == CH_STAR || req.in_byte == CH_UNDER ||
          req.in_byte == CH_TILDE || req.in_byte == CH_BSL) begin
        run.push_back(CH_BSL);
      end
      run.push_back(req.in_byte);
    end
    open_style = next_style;
    foreach (run[i]) begin
      md_bytes_due.push_back(out_item_t'{run[i], (i == run.size() - 1)});
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      open_style = '0;
      md_bytes_due.delete();
      errors = 0;
      requests = 0;
      bytes_checked = 0;
    end else begin
      if (push && !full) begin
        requests++;
        predict_markdown(in_item);
      end
      if (pop && !empty) begin
        bytes_checked++;
        if (md_bytes_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result byte %02h last %0b", $realtime,
                     out_item.out_byte, out_item.last_of_run);
          end
        end else begin
          want = md_bytes_due.pop_front();
          if (out_item.out_byte !== want.out_byte ||
              out_item.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                       $realtime, want.out_byte, want.last_of_run,
                       out_item.out_byte, out_item.last_of_run);
            end
          end
        end
      end
    end
    pending = md_bytes_due.size();
  end

endmodule

@@ test/tb_markdown_emphasis_serializer_top.sv @@
`timescale 1ns / 1ps

module tb_markdown_emphasis_serializer_top;
  import mes_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 260;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  int errors;
  int pending;
  int requests;
  int bytes_checked;

  bit no_gaps = 1'b0;
  int pop_hold = 0;
  int idle_cycles = 0;
  int text_items = 0;
  bit drained_once = 1'b0;

  markdown_emphasis_serializer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  mes_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_item       (in_item),
    .empty         (empty),
    .pop           (pop),
    .out_item      (out_item),
    .errors        (errors),
    .pending       (pending),
    .requests      (requests),
    .bytes_checked (bytes_checked)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return CH_STAR;
        1: return CH_UNDER;
        2: return CH_TILDE;
        default: return CH_BSL;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [STYLE_W-1:0] style,
                              input logic [7:0] text);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= in_item_t'{cmd, style, text};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int r;
    int burst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, escapes, style transitions
    send_request(CMD_BYTE, 3'd7, 8'h00);
    send_request(CMD_BYTE, 3'd0, 8'hFF);
    send_request(CMD_BYTE, 3'd2, CH_STAR);
    send_request(CMD_BYTE, 3'd5, CH_UNDER);
    send_request(CMD_BYTE, 3'd1, CH_TILDE);
    send_request(CMD_BYTE, 3'd6, CH_BSL);
    send_request(CMD_PART, 3'd7, 8'hFF);
    send_request(CMD_PART, 3'd7, 8'h00);   // same style, nothing emitted
    send_request(CMD_END, 3'd7, 8'hFF);    // all three open: five tokens and nul
    send_request(CMD_END, 3'd0, 8'h00);    // nothing open: nul only
    send_request(CMD_PART, 3'd3, 8'h2A);   // bold and italic run together
    send_request(CMD_PART, 3'd4, 8'h00);   // close both, open strike
    send_request(CMD_PART, 3'd0, 8'h00);
    send_request(CMD_NONE, 3'd7, 8'hFF);   // unused command
    send_request(CMD_PART, 3'd2, 8'h00);
    send_request(CMD_PART, 3'd1, 8'h55);
    send_request(CMD_NONE, 3'd0, 8'h00);
    send_request(CMD_PART, 3'd6, 8'hAA);
    send_request(CMD_BYTE, 3'd0, 8'h61);
    send_request(CMD_END, 3'd5, 8'hA5);

    // random: mostly parts of styled text, some noise
    while (text_items < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if (!drained_once && text_items >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_request(CMD_PART, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        text_items++;
        burst = $urandom_range(0, 8);
        repeat (burst) begin
          send_request(CMD_BYTE, 3'($urandom_range(0, 7)), pick_text_byte());
          text_items++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_request(CMD_END, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
          text_items++;
        end
      end else if (r < 92) begin
        send_request(CMD_NONE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        send_request(CMD_END, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        text_items++;
      end
    end

    no_gaps = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("run covered %0d requests and %0d result bytes, with random stalls on both sides",
             requests, bytes_checked);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
